// ===== rtl/rwl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared types and codes for the packed reader-writer lock.
// ----------------------------------------------------------------------------
package rwl_pkg;

   localparam int ATTEMPT_BITS   = 16;
   localparam int MODE_BITS      = 3;
   localparam int STATUS_BITS    = 3;
   localparam int OUT_COUNT_BITS = 10;

   localparam logic [MODE_BITS-1:0] MODE_ACQ_WRITE = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_ACQ_READ  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_REL_WRITE = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_REL_READ  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_TRY_WRITE = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_TRY_READ  = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_CLAIM     = 3'd6;

   localparam logic [STATUS_BITS-1:0] ST_GRANTED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_BUSY     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_QUEUED   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_RELEASED = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_ERROR    = 3'd4;

   typedef struct packed {
      logic [MODE_BITS-1:0]    mode;
      logic [ATTEMPT_BITS-1:0] attempt;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0]    status;
      logic                      wake_writer;
      logic [OUT_COUNT_BITS-1:0] wake_reader_count;
      logic                      is_owned;
      logic [OUT_COUNT_BITS-1:0] reader_owners;
      logic [OUT_COUNT_BITS-1:0] writer_waiters;
   } rsp_type;

   typedef struct packed {
      logic owned;
      logic waking;
   } flags_type;

endpackage

// ===== rtl/packed_reader_writer_lock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_reader_writer_lock
// Hardware reader-writer lock: one request item in, one result item out.
// Path: an accepted item passes the input register, then the result register,
// which raises rsp_valid and holds the result while rsp_ready is low.
// Throughput: one item per cycle while rsp_ready is high; lock state is updated
// as an item moves into the result register, so the next item sees it at once.
// Reset (synchronous): lock free, all counters zero, spin_limit zero.
// ----------------------------------------------------------------------------
module packed_reader_writer_lock
   import rwl_pkg::*;
#(
   parameter int COUNT_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_type                 rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [ATTEMPT_BITS-1:0] csr_data
);

   logic                    in_valid_ff;
   req_type                 in_data_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;
   rsp_type                 rsp_data_in;
   logic [ATTEMPT_BITS-1:0] spin_limit_ff;
   flags_type               flags_ff;
   flags_type               flags_in;
   logic [COUNT_BITS-1:0]   readers_ff;
   logic [COUNT_BITS-1:0]   readers_in;
   logic [COUNT_BITS-1:0]   rwait_ff;
   logic [COUNT_BITS-1:0]   rwait_in;
   logic [COUNT_BITS-1:0]   wwait_ff;
   logic [COUNT_BITS-1:0]   wwait_in;
   logic                    advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rwl_core #(
      .COUNT_BITS(COUNT_BITS)
   ) u_core (
      .req             (in_data_ff),
      .spin_limit      (spin_limit_ff),
      .flags           (flags_ff),
      .readers         (readers_ff),
      .reader_waits    (rwait_ff),
      .writer_waits    (wwait_ff),
      .flags_in        (flags_in),
      .readers_in      (readers_in),
      .reader_waits_in (rwait_in),
      .writer_waits_in (wwait_in),
      .rsp             (rsp_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         spin_limit_ff <= '0;
         flags_ff      <= '0;
         readers_ff    <= '0;
         rwait_ff      <= '0;
         wwait_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            flags_ff     <= flags_in;
            readers_ff   <= readers_in;
            rwait_ff     <= rwait_in;
            wwait_ff     <= wwait_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            spin_limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/rwl_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwl_core
// Next-state and result logic for one lock request.
// ----------------------------------------------------------------------------
module rwl_core
   import rwl_pkg::*;
#(
   parameter int COUNT_BITS = 10
) (
   input  req_type                 req,
   input  logic [ATTEMPT_BITS-1:0] spin_limit,
   input  flags_type               flags,
   input  logic [COUNT_BITS-1:0]   readers,
   input  logic [COUNT_BITS-1:0]   reader_waits,
   input  logic [COUNT_BITS-1:0]   writer_waits,
   output flags_type               flags_in,
   output logic [COUNT_BITS-1:0]   readers_in,
   output logic [COUNT_BITS-1:0]   reader_waits_in,
   output logic [COUNT_BITS-1:0]   writer_waits_in,
   output rsp_type                 rsp
);

   logic                  may_queue;
   logic                  readers_full;
   logic                  rwait_full;
   logic                  wwait_full;
   logic                  readers_zero;
   logic                  wwait_zero;
   logic [STATUS_BITS-1:0] status;
   logic                  wake_w;
   logic [COUNT_BITS-1:0] wake_r;
   logic [COUNT_BITS+OUT_COUNT_BITS-1:0] ext_wake;
   logic [COUNT_BITS+OUT_COUNT_BITS-1:0] ext_readers;
   logic [COUNT_BITS+OUT_COUNT_BITS-1:0] ext_wwait;

   assign may_queue    = (req.attempt >= spin_limit);
   assign readers_full = &readers;
   assign rwait_full   = &reader_waits;
   assign wwait_full   = &writer_waits;
   assign readers_zero = (readers == '0);
   assign wwait_zero   = (writer_waits == '0);

   always_comb begin
      flags_in        = flags;
      readers_in      = readers;
      reader_waits_in = reader_waits;
      writer_waits_in = writer_waits;
      status          = ST_ERROR;
      wake_w          = 1'b0;
      wake_r          = '0;
      case (req.mode)
         MODE_ACQ_WRITE: begin
            if (!flags.owned && !flags.waking) begin
               flags_in.owned = 1'b1;
               status         = ST_GRANTED;
            end else if (may_queue) begin
               if (!wwait_full) begin
                  writer_waits_in = writer_waits + 1'b1;
                  status          = ST_QUEUED;
               end
            end else begin
               status = ST_BUSY;
            end
         end
         MODE_ACQ_READ: begin
            if (!flags.owned && readers_zero && !flags.waking && wwait_zero) begin
               flags_in.owned = 1'b1;
               readers_in     = {{(COUNT_BITS-1){1'b0}}, 1'b1};
               status         = ST_GRANTED;
            end else if (flags.owned && !readers_zero && !flags.waking && wwait_zero) begin
               if (!readers_full) begin
                  readers_in = readers + 1'b1;
                  status     = ST_GRANTED;
               end
            end else if (may_queue) begin
               if (!rwait_full) begin
                  reader_waits_in = reader_waits + 1'b1;
                  status          = ST_QUEUED;
               end
            end else begin
               status = ST_BUSY;
            end
         end
         MODE_REL_WRITE: begin
            if (flags.owned && readers_zero) begin
               flags_in.owned = 1'b0;
               status         = ST_RELEASED;
               if (!wwait_zero) begin
                  flags_in.waking = 1'b1;
                  writer_waits_in = writer_waits - 1'b1;
                  wake_w          = 1'b1;
               end else begin
                  wake_r          = reader_waits;
                  reader_waits_in = '0;
               end
            end
         end
         MODE_REL_READ: begin
            if (flags.owned && !readers_zero) begin
               status = ST_RELEASED;
               if (readers != {{(COUNT_BITS-1){1'b0}}, 1'b1}) begin
                  readers_in = readers - 1'b1;
               end else begin
                  flags_in.owned = 1'b0;
                  readers_in     = '0;
                  if (!wwait_zero) begin
                     flags_in.waking = 1'b1;
                     writer_waits_in = writer_waits - 1'b1;
                     wake_w          = 1'b1;
                  end
               end
            end
         end
         MODE_TRY_WRITE: begin
            if (flags.owned || flags.waking) begin
               status = ST_BUSY;
            end else begin
               flags_in.owned = 1'b1;
               status         = ST_GRANTED;
            end
         end
         MODE_TRY_READ: begin
            if (flags.waking || !wwait_zero) begin
               status = ST_BUSY;
            end else if (!flags.owned) begin
               if (!readers_full) begin
                  readers_in     = readers + 1'b1;
                  flags_in.owned = 1'b1;
                  status         = ST_GRANTED;
               end
            end else if (!readers_zero) begin
               if (!readers_full) begin
                  readers_in = readers + 1'b1;
                  status     = ST_GRANTED;
               end
            end else begin
               status = ST_BUSY;
            end
         end
         MODE_CLAIM: begin
            if (flags.waking && !flags.owned) begin
               flags_in.waking = 1'b0;
               flags_in.owned  = 1'b1;
               status          = ST_GRANTED;
            end
         end
         default: begin
            status = ST_ERROR;
         end
      endcase
   end

   // counts leave at the fixed result width, zero-extended or truncated
   assign ext_wake    = {{OUT_COUNT_BITS{1'b0}}, wake_r};
   assign ext_readers = {{OUT_COUNT_BITS{1'b0}}, readers_in};
   assign ext_wwait   = {{OUT_COUNT_BITS{1'b0}}, writer_waits_in};

   always_comb begin
      rsp.status            = status;
      rsp.wake_writer       = wake_w;
      rsp.wake_reader_count = ext_wake[OUT_COUNT_BITS-1:0];
      rsp.is_owned          = flags_in.owned;
      rsp.reader_owners     = ext_readers[OUT_COUNT_BITS-1:0];
      rsp.writer_waiters    = ext_wwait[OUT_COUNT_BITS-1:0];
   end

endmodule
